>>> hdl/cssr_pkg.sv
// Shared constants, types and tables of the shadow RAM configuration block.
package cssr_pkg;

  localparam logic [1:0] OP_IO_READ  = 2'd0;
  localparam logic [1:0] OP_IO_WRITE = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  localparam logic [15:0] PORT_INDEX = 16'h0022;
  localparam logic [15:0] PORT_DATA  = 16'h0024;

  localparam int REG_COUNT = 13;
  localparam logic [3:0] REG_LAST = 4'hc;
  localparam logic [3:0] REG_BANK = 4'h2;

  // Offsets of the bytes that steer routing (index minus 0x20)
  localparam logic [3:0] OFS_E_CTL   = 4'h4;
  localparam logic [3:0] OFS_D_CTL   = 4'h5;
  localparam logic [3:0] OFS_C_CTL   = 4'h6;
  localparam logic [3:0] OFS_F_CTL   = 4'h3;
  localparam logic [3:0] OFS_PROTECT = 4'h7;

  localparam logic [1:0] ROUTE_INTERNAL = 2'd0;
  localparam logic [1:0] ROUTE_EXTERNAL = 2'd1;
  localparam logic [1:0] ROUTE_DISABLED = 2'd2;

  localparam logic [7:0] READ_FLOAT = 8'hff;

  typedef struct packed {
    logic [7:0] c_ctl;
    logic [7:0] d_ctl;
    logic [7:0] e_ctl;
    logic [7:0] f_ctl;
    logic [7:0] protect;
  } route_cfg_t;

  typedef struct packed {
    logic       read_route;
    logic [1:0] write_route;
    logic       region_covered;
  } route_t;

  function automatic logic [7:0] write_mask(input logic [3:0] ofs);
    case (ofs)
      4'h0:    write_mask = 8'h3f;
      4'h1:    write_mask = 8'hf3;
      4'h9:    write_mask = 8'h0f;
      default: write_mask = 8'hff;
    endcase
  endfunction

  function automatic logic [7:0] reset_value(input logic [3:0] ofs);
    case (ofs)
      4'h2:    reset_value = 8'hf0;
      4'h3:    reset_value = 8'h40;
      4'h8:    reset_value = 8'h08;
      4'h9:    reset_value = 8'ha0;
      default: reset_value = 8'h00;
    endcase
  endfunction

endpackage

>>> hdl/cssr_if.sv
// Request and response channel interfaces of the shadow RAM configuration block.
interface cssr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] io_port;
  logic [7:0]  write_data;
  logic [19:0] mem_address;

  modport source(output valid, operation, io_port, write_data, mem_address, input ready);
  modport sink(input valid, operation, io_port, write_data, mem_address, output ready);
endinterface

interface cssr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_route;
  logic [1:0] write_route;
  logic       region_covered;

  modport source(output valid, read_data, read_route, write_route, region_covered,
                 input ready);
  modport sink(input valid, read_data, read_route, write_route, region_covered,
               output ready);
endinterface

>>> hdl/cssr_regs.sv
// Index register and configuration byte file with masked writes.
module cssr_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [15:0]            port,
  input  logic [7:0]             data,
  output logic [7:0]             rd_byte,
  output cssr_pkg::route_cfg_t   route_cfg
);

  logic [7:0] index_register;
  logic [7:0] config_bytes [cssr_pkg::REG_COUNT];
  logic [3:0] offset;
  logic       idx_ok;

  assign offset = index_register[3:0];
  assign idx_ok = (index_register[7:4] == cssr_pkg::REG_BANK) &&
                  (offset <= cssr_pkg::REG_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      index_register <= 8'h00;
      for (int i = 0; i < cssr_pkg::REG_COUNT; i++) begin
        config_bytes[i] <= cssr_pkg::reset_value(4'(i));
      end
    end else if (wr_en) begin
      if (port == cssr_pkg::PORT_INDEX) begin
        index_register <= data;
      end else if (port == cssr_pkg::PORT_DATA && idx_ok) begin
        config_bytes[offset] <= data & cssr_pkg::write_mask(offset);
      end
    end
  end

  // unimplemented indices read as zero
  assign rd_byte = idx_ok ? config_bytes[offset] : 8'h00;

  assign route_cfg.c_ctl   = config_bytes[cssr_pkg::OFS_C_CTL];
  assign route_cfg.d_ctl   = config_bytes[cssr_pkg::OFS_D_CTL];
  assign route_cfg.e_ctl   = config_bytes[cssr_pkg::OFS_E_CTL];
  assign route_cfg.f_ctl   = config_bytes[cssr_pkg::OFS_F_CTL];
  assign route_cfg.protect = config_bytes[cssr_pkg::OFS_PROTECT];

endmodule

>>> hdl/cssr_route.sv
// Shadow segment decode: read and write routing for an upper-memory address.
module cssr_route (
  input  logic [19:0]          address,
  input  cssr_pkg::route_cfg_t route_cfg,
  output cssr_pkg::route_t     route
);

  logic       covered;
  logic       top_seg;
  logic [1:0] bank;
  logic [1:0] seg;
  logic [7:0] ctl;

  assign covered = (address[19:18] == 2'b11);
  assign top_seg = (address[19:16] == 4'hf);
  assign bank    = address[17:16];
  assign seg     = address[15:14];

  always_comb begin
    case (bank)
      2'd0:    ctl = route_cfg.c_ctl;
      2'd1:    ctl = route_cfg.d_ctl;
      default: ctl = route_cfg.e_ctl;
    endcase
  end

  always_comb begin
    route = '0;
    if (covered) begin
      route.region_covered = 1'b1;
      if (top_seg) begin
        route.read_route  = route_cfg.f_ctl[6];
        route.write_route = route_cfg.protect[7] ? cssr_pkg::ROUTE_DISABLED
                                                 : cssr_pkg::ROUTE_INTERNAL;
      end else begin
        // high nibble enables internal reads, low nibble internal writes
        route.read_route = ~ctl[{1'b1, seg}];
        if (route_cfg.protect[{1'b1, bank}]) begin
          route.write_route = cssr_pkg::ROUTE_DISABLED;
        end else begin
          route.write_route = ctl[{1'b0, seg}] ? cssr_pkg::ROUTE_INTERNAL
                                               : cssr_pkg::ROUTE_EXTERNAL;
        end
      end
    end
  end

endmodule

>>> hdl/chipset_shadow_ram_config_regs_top.sv
// Top level of the shadow RAM configuration block.
//
// req carries one word per bus access or routing query: operation 0 reads an
// I/O port, 1 writes one, 2 asks how a memory address is routed. Port 0x22
// loads the index, port 0x24 reads or writes the indexed configuration byte
// (0x20..0x2c); other ports read as 0xff and ignore writes.
// rsp returns exactly one word per request: read_data for I/O reads, or the
// read route, write route and coverage flag for queries; unused fields are 0.
// rsp.valid rises in the cycle after acceptance; one word per cycle is sustained
// while rsp is not stalled, through the single result register after decode.
// Register writes take effect at acceptance, so the next word sees them.
// A stalled rsp holds its word; req.ready stays high while the result register
// is empty or is being drained in the same cycle.
// Reset clears the index, loads the configuration defaults and empties the
// result register; no clearing pass is needed.
module chipset_shadow_ram_config_regs_top (
  input logic       clk,
  input logic       rst,
  cssr_req_if.sink  req,
  cssr_rsp_if.source rsp
);

  logic                 accept;
  logic                 wr_en;
  logic [7:0]           rd_byte;
  cssr_pkg::route_cfg_t route_cfg;
  cssr_pkg::route_t     route;
  logic [7:0]           read_data_next;
  cssr_pkg::route_t     route_next;

  assign req.ready = ~rsp.valid | rsp.ready;
  assign accept    = req.valid & req.ready;
  assign wr_en     = accept && (req.operation == cssr_pkg::OP_IO_WRITE);

  cssr_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .port      (req.io_port),
    .data      (req.write_data),
    .rd_byte   (rd_byte),
    .route_cfg (route_cfg)
  );

  cssr_route u_route (
    .address   (req.mem_address),
    .route_cfg (route_cfg),
    .route     (route)
  );

  always_comb begin
    read_data_next = 8'h00;
    route_next     = '0;
    case (req.operation)
      cssr_pkg::OP_IO_READ: begin
        read_data_next = (req.io_port == cssr_pkg::PORT_DATA) ? rd_byte
                                                              : cssr_pkg::READ_FLOAT;
      end
      cssr_pkg::OP_QUERY: begin
        route_next = route;
      end
      default: begin
        read_data_next = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (req.ready) begin
      rsp.valid <= req.valid;
    end
  end

  // hold the word while the receiver stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_data      <= read_data_next;
      rsp.read_route     <= route_next.read_route;
      rsp.write_route    <= route_next.write_route;
      rsp.region_covered <= route_next.region_covered;
    end
  end

endmodule

>>> hdl/cssr_checker.sv
// Port-level assertions for the shadow RAM configuration block, bound to the top.
module cssr_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_operation,
  input logic [19:0] req_mem_address,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [7:0]  rsp_read_data,
  input logic        rsp_read_route,
  input logic [1:0]  rsp_write_route,
  input logic        rsp_region_covered
);

  logic req_accept;
  assign req_accept = req_valid & req_ready;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
      $stable(rsp_write_route) && $stable(rsp_read_route))
    else $error("stalled response word changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request blocked with empty result register");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    req_accept && req_operation == cssr_pkg::OP_IO_WRITE |=>
      rsp_valid && rsp_read_data == 8'h00 && !rsp_read_route &&
      rsp_write_route == cssr_pkg::ROUTE_INTERNAL && !rsp_region_covered)
    else $error("io write response not all zero");

  a_low_query: assert property (@(posedge clk) disable iff (rst)
    req_accept && req_operation == cssr_pkg::OP_QUERY && req_mem_address[19:18] != 2'b11
      |=> rsp_valid && !rsp_region_covered && !rsp_read_route &&
      rsp_write_route == cssr_pkg::ROUTE_INTERNAL && rsp_read_data == 8'h00)
    else $error("query below shadow region reported routing");

  a_route_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_write_route != 2'd3)
    else $error("undefined write route code");

endmodule

bind chipset_shadow_ram_config_regs_top cssr_checker u_cssr_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .req_operation      (req.operation),
  .req_mem_address    (req.mem_address),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_read_data      (rsp.read_data),
  .rsp_read_route     (rsp.read_route),
  .rsp_write_route    (rsp.write_route),
  .rsp_region_covered (rsp.region_covered)
);
